[sv/rpat_pkg.sv]
// Shared types, codes and helper functions of the periodic alarm timer.
package rpat_pkg;

    localparam int TICKS_W    = 24;
    localparam int PERIOD_W   = 41;
    localparam int CFG_IDX_W  = 2;

    localparam logic [TICKS_W-1:0] TICKS_RESET = 24'd218750;

    // Request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_CTRL  = 2'd1;
    localparam logic [1:0] REQ_TIME  = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // Alarm register indexes
    localparam logic [1:0] IDX_SECOND = 2'd0;
    localparam logic [1:0] IDX_MINUTE = 2'd1;
    localparam logic [1:0] IDX_HOUR   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IRQ_EN = 2'd2;

    // Status codes and control bits
    localparam logic [7:0] STATUS_PERIOD = 8'h40;
    localparam logic [7:0] STATUS_ALARM  = 8'h80;
    localparam int CTRL_ALARM_BIT = 3;
    localparam int CTRL_COUNT_BIT = 2;

    // Period setting codes: off, shifted tick rate and multiplied periods
    localparam logic [3:0] SET_OFF    = 4'd0;
    localparam logic [3:0] SET_SHIFT  = 4'd12;
    localparam logic [3:0] SET_MINUTE = 4'd13;
    localparam logic [3:0] SET_HOUR   = 4'd14;

    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] reg_index;
        logic [7:0] write_data;
        logic [4:0] now_hour;
        logic [5:0] now_minute;
        logic [5:0] now_second;
    } req_word_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       flag_level;
        logic       irq_request;
    } rsp_word_t;

    typedef struct packed {
        logic [TICKS_W-1:0] ticks_per_second;
        logic               flag_invert;
        logic               irq_enable;
    } cfg_t;

    // Reload value of the periodic counter for a control setting
    function automatic logic [PERIOD_W-1:0] period_for(
        input logic [3:0]         setting,
        input logic [TICKS_W-1:0] tps
    );
        logic [PERIOD_W-1:0] t;
        logic [PERIOD_W-1:0] p;
        begin
            t = {{(PERIOD_W-TICKS_W){1'b0}}, tps};
            if (setting == SET_OFF)
                p = '0;
            else if (setting <= SET_SHIFT)
                p = t >> (SET_SHIFT - setting);
            else if (setting == SET_MINUTE)
                p = t * 41'd60;
            else if (setting == SET_HOUR)
                p = t * 41'd3600;
            else
                p = t * 41'd86400;
            return p;
        end
    endfunction

    // Two BCD digits to binary, no digit check, kept to 8 bits
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
        logic [7:0] hi;
        begin
            hi = {4'd0, v[7:4]};
            return 8'((hi << 3) + (hi << 1) + {4'd0, v[3:0]});
        end
    endfunction

endpackage

[sv/rtc_periodic_alarm_timer.sv]
// Top level of the real-time clock periodic interrupt and alarm timer.
//
// Request channel (req_valid / req_stall / req_word): each word is a tick,
// a control write, an alarm time write (BCD) or a status read. A word is
// taken when req_valid is high and req_stall is low.
// Response channel (rsp_valid / rsp_stall / rsp_word): exactly one word per
// request, in order, carrying the status byte on a read (zero otherwise),
// the flag line after optional inversion and the interrupt request level.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
// index 0 ticks per second, 1 flag inversion, 2 interrupt enable. Always
// ready; write only while no request is in flight.
// Path: input register, then timer update into the response register, which
// holds the word while rsp_stall is high. Throughput: one word per cycle
// while rsp_stall is low; the timer update is a single decrement and compare
// per counter, plus the period multiply on control writes.
// Reset: counters, status and alarm registers clear, the flag is released,
// the half-second counter loads half the reset tick rate, and both
// channels come up empty.
// Stall: while rsp_stall holds a response, the input register keeps one
// word and then req_stall rises; nothing is dropped or repeated.
module rtc_periodic_alarm_timer
    import rpat_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_word_t            req_word,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_word_t            rsp_word,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICKS_W-1:0]   cfg_data
);

    cfg_t      cfg_reg;
    logic      in_vld_reg, in_vld_next;
    req_word_t in_word_reg;
    logic      out_vld_reg, out_vld_next;
    rsp_word_t out_word_reg;
    rsp_word_t rsp_next;
    logic      advance;
    logic      take;

    // Advance the held word into the response register when that is free
    assign advance   = in_vld_reg && (!out_vld_reg || !rsp_stall);
    assign req_stall = in_vld_reg && !advance;
    assign take      = req_valid && !req_stall;
    assign cfg_ready = 1'b1;

    assign in_vld_next  = take || (in_vld_reg && !advance);
    assign out_vld_next = advance || (out_vld_reg && rsp_stall);

    assign rsp_valid = out_vld_reg;
    assign rsp_word  = out_word_reg;

    rpat_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .req      (in_word_reg),
        .cfg      (cfg_reg),
        .rsp_next (rsp_next)
    );

    // Configuration registers; an unknown index is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_second <= TICKS_RESET;
            cfg_reg.flag_invert      <= 1'b0;
            cfg_reg.irq_enable       <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TICKS:  cfg_reg.ticks_per_second <= cfg_data;
                CFG_INVERT: cfg_reg.flag_invert      <= cfg_data[0];
                CFG_IRQ_EN: cfg_reg.irq_enable       <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers: hold while stalled
    always_ff @(posedge clk)
    begin
        if (take)
            in_word_reg <= req_word;
        if (advance)
            out_word_reg <= rsp_next;
    end

endmodule

[sv/rpat_core.sv]
// Timer state and per-word update of the periodic alarm timer.
module rpat_core
    import rpat_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  req_word_t req,
    input  cfg_t      cfg,
    output rsp_word_t rsp_next
);

    logic [7:0]          ctrl_reg,   ctrl_next;
    logic [7:0]          status_reg, status_next;
    logic                flag_reg,   flag_next;
    logic                irq_reg,    irq_next;
    logic [PERIOD_W-1:0] reload_reg, reload_next;
    logic [PERIOD_W-1:0] count_reg,  count_next;
    logic [TICKS_W-1:0]  alarm_cnt_reg, alarm_cnt_next;
    logic [7:0]          alm_sec_reg, alm_sec_next;
    logic [7:0]          alm_min_reg, alm_min_next;
    logic [7:0]          alm_hour_reg, alm_hour_next;
    logic [PERIOD_W-1:0] new_reload;
    logic [7:0]          bcd_val;
    logic                time_match;

    assign new_reload = period_for(req.write_data[7:4], cfg.ticks_per_second);
    assign bcd_val    = bcd_to_bin(req.write_data);
    assign time_match = ({3'd0, req.now_hour}   == alm_hour_reg)
                     && ({2'd0, req.now_minute} == alm_min_reg)
                     && ({2'd0, req.now_second} == alm_sec_reg);

    always_comb
    begin
        ctrl_next      = ctrl_reg;
        status_next    = status_reg;
        flag_next      = flag_reg;
        irq_next       = irq_reg;
        reload_next    = reload_reg;
        count_next     = count_reg;
        alarm_cnt_next = alarm_cnt_reg;
        alm_sec_next   = alm_sec_reg;
        alm_min_next   = alm_min_reg;
        alm_hour_next  = alm_hour_reg;
        rsp_next.read_data = 8'd0;
        case (req.req_type)
            REQ_TICK:
            begin
                // period first, so an alarm in the same tick wins the status
                if (count_reg != '0)
                begin
                    if (count_reg == PERIOD_W'(1))
                    begin
                        count_next  = reload_reg;
                        status_next = STATUS_PERIOD;
                        flag_next   = 1'b0;
                        if (cfg.irq_enable)
                            irq_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg - PERIOD_W'(1);
                    end
                end
                if (alarm_cnt_reg != '0 && ctrl_reg[CTRL_ALARM_BIT])
                begin
                    if (alarm_cnt_reg == TICKS_W'(1))
                    begin
                        alarm_cnt_next = cfg.ticks_per_second >> 1;
                        if (time_match)
                        begin
                            status_next = STATUS_ALARM;
                            flag_next   = 1'b0;
                            if (cfg.irq_enable)
                                irq_next = 1'b1;
                        end
                    end
                    else
                    begin
                        alarm_cnt_next = alarm_cnt_reg - TICKS_W'(1);
                    end
                end
            end
            REQ_CTRL:
            begin
                ctrl_next   = req.write_data;
                status_next = 8'd0;
                flag_next   = 1'b1;
                irq_next    = 1'b0;
                reload_next = new_reload;
                count_next  = req.write_data[CTRL_COUNT_BIT] ? new_reload : '0;
            end
            REQ_TIME:
            begin
                if (ctrl_reg[CTRL_ALARM_BIT])
                begin
                    case (req.reg_index)
                        IDX_SECOND: alm_sec_next  = bcd_val;
                        IDX_MINUTE: alm_min_next  = bcd_val;
                        IDX_HOUR:   alm_hour_next = bcd_val;
                        default:    ;
                    endcase
                end
            end
            REQ_READ:
            begin
                rsp_next.read_data = status_reg;
            end
            default: ;
        endcase
        rsp_next.flag_level  = flag_next ^ cfg.flag_invert;
        rsp_next.irq_request = irq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg      <= 8'd0;
            status_reg    <= 8'd0;
            flag_reg      <= 1'b1;
            irq_reg       <= 1'b0;
            reload_reg    <= '0;
            count_reg     <= '0;
            alarm_cnt_reg <= TICKS_RESET >> 1;
            alm_sec_reg   <= 8'd0;
            alm_min_reg   <= 8'd0;
            alm_hour_reg  <= 8'd0;
        end
        else if (advance)
        begin
            ctrl_reg      <= ctrl_next;
            status_reg    <= status_next;
            flag_reg      <= flag_next;
            irq_reg       <= irq_next;
            reload_reg    <= reload_next;
            count_reg     <= count_next;
            alarm_cnt_reg <= alarm_cnt_next;
            alm_sec_reg   <= alm_sec_next;
            alm_min_reg   <= alm_min_next;
            alm_hour_reg  <= alm_hour_next;
        end
    end

endmodule

[sim/tb.sv]
// Self-checking testbench of the periodic interrupt and alarm timer.
`timescale 1ns / 1ps

module tb;
    import rpat_pkg::*;

    // Worst case: about 112k request words (the half-second counter has to
    // run down from its reset load once), each possibly slowed by a sender
    // gap, a response stall and the block's registers. Allow several times
    // that before calling the run hung.
    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 195;
    localparam int REQ_W       = $bits(req_word_t);

    // Time register index with no register behind it
    localparam logic [1:0] IDX_NONE = 2'd3;

    // Tracks the timer state and holds the response words still owed by the block
    class rtc_irq_tracker;
        logic [TICKS_W-1:0]  tps;
        logic                inv;
        logic                irq_en;
        logic [7:0]          ctrl;
        logic [7:0]          status;
        logic                flag;
        logic                irq;
        logic [PERIOD_W-1:0] reload;
        logic [PERIOD_W-1:0] count;
        logic [TICKS_W-1:0]  half_cnt;
        logic [7:0]          al_sec;
        logic [7:0]          al_min;
        logic [7:0]          al_hour;
        rsp_word_t           due_words[$];
        int                  errors;
        int                  checked;
        int                  expiries;
        int                  alarm_hits;

        function new();
            tps        = TICKS_RESET;
            inv        = 1'b0;
            irq_en     = 1'b0;
            ctrl       = '0;
            status     = '0;
            flag       = 1'b1;
            irq        = 1'b0;
            reload     = '0;
            count      = '0;
            half_cnt   = TICKS_RESET >> 1;
            al_sec     = '0;
            al_min     = '0;
            al_hour    = '0;
            errors     = 0;
            checked    = 0;
            expiries   = 0;
            alarm_hits = 0;
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TICKS_W-1:0] data);
            case (idx)
                CFG_TICKS:  tps    = data;
                CFG_INVERT: inv    = data[0];
                CFG_IRQ_EN: irq_en = data[0];
                default: ;
            endcase
        endfunction

        // Reload length of the periodic counter for a setting nibble
        function logic [PERIOD_W-1:0] reload_len(logic [3:0] setting);
            logic [63:0] t;
            t = 64'(tps);
            if (setting == SET_OFF)
                return '0;
            if (setting <= SET_SHIFT)
                return PERIOD_W'(t >> (SET_SHIFT - setting));
            if (setting == SET_MINUTE)
                return PERIOD_W'(t * 60);
            if (setting == SET_HOUR)
                return PERIOD_W'(t * 3600);
            return PERIOD_W'(t * 86400);
        endfunction

        function void raise_event(logic [7:0] code);
            status = code;
            flag   = 1'b0;
            if (irq_en)
                irq = 1'b1;
        endfunction

        // Advance the timer state by one accepted request word and queue its response
        function void take_request(req_word_t w);
            rsp_word_t  r;
            logic [7:0] bin;
            r.read_data = '0;
            case (w.req_type)
                REQ_TICK:
                begin
                    if (count != 0)
                    begin
                        count = count - 1'b1;
                        if (count == 0)
                        begin
                            count = reload;
                            raise_event(STATUS_PERIOD);
                            expiries++;
                        end
                    end
                    if (half_cnt != 0 && ctrl[CTRL_ALARM_BIT])
                    begin
                        half_cnt = half_cnt - 1'b1;
                        if (half_cnt == 0)
                        begin
                            half_cnt = tps >> 1;
                            if ({3'd0, w.now_hour} == al_hour && {2'd0, w.now_minute} == al_min
                                && {2'd0, w.now_second} == al_sec)
                            begin
                                raise_event(STATUS_ALARM);
                                alarm_hits++;
                            end
                        end
                    end
                end
                REQ_CTRL:
                begin
                    ctrl   = w.write_data;
                    status = '0;
                    flag   = 1'b1;
                    irq    = 1'b0;
                    reload = reload_len(ctrl[7:4]);
                    count  = ctrl[CTRL_COUNT_BIT] ? reload : '0;
                end
                REQ_TIME:
                begin
                    if (ctrl[CTRL_ALARM_BIT])
                    begin
                        bin = 8'(w.write_data[7:4] * 10 + w.write_data[3:0]);
                        case (w.reg_index)
                            IDX_SECOND: al_sec  = bin;
                            IDX_MINUTE: al_min  = bin;
                            IDX_HOUR:   al_hour = bin;
                            default: ;
                        endcase
                    end
                end
                default: r.read_data = status;
            endcase
            r.flag_level  = flag ^ inv;
            r.irq_request = irq;
            due_words.push_back(r);
        endfunction

        task report(string what);
            errors++;
            $display("MISMATCH: %s", what);
        endtask

        task match_response(rsp_word_t got);
            rsp_word_t want;
            checked++;
            if (due_words.size() == 0)
            begin
                report($sformatf("response word %h arrived with nothing outstanding", got));
                return;
            end
            want = due_words.pop_front();
            if (got.read_data !== want.read_data)
                report($sformatf("response %0d read_data %h, want %h",
                                 checked, got.read_data, want.read_data));
            if (got.flag_level !== want.flag_level)
                report($sformatf("response %0d flag_level %b, want %b",
                                 checked, got.flag_level, want.flag_level));
            if (got.irq_request !== want.irq_request)
                report($sformatf("response %0d irq_request %b, want %b",
                                 checked, got.irq_request, want.irq_request));
        endtask
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    req_word_t            req_word  = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_word_t            rsp_word;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_TICKS;
    logic [TICKS_W-1:0]   cfg_data  = '0;

    rtc_irq_tracker tracker = new();
    bit             calm    = 1'b0;
    int             cycles  = 0;
    int             sent    = 0;

    rtc_periodic_alarm_timer dut (.*);

    always #1 clk = ~clk;

    // Hang guard: give up well beyond the slowest correct run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("run stopped at the cycle limit, %0d words still owed", tracker.pending());
            $display("rtc_periodic_alarm_timer regression: fail");
            $finish;
        end
    end

    // Response side: alternate free stretches with stall bursts; hold the
    // stall low altogether once the run turns calm
    initial
    begin
        forever
        begin
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if (!calm)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    // Check every response word that the block hands over
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            tracker.match_response(rsp_word);
    end

    // Offer one word and hold it until taken; valid stays high on return,
    // so the caller must either offer the next word or drop valid at once
    task automatic send(input req_word_t w);
        req_valid <= 1'b1;
        req_word  <= w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        tracker.take_request(w);
        sent++;
    endtask

    task automatic idle_gap();
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
    endtask

    // Write one register; cfg_valid is left high for the caller to drop
    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [TICKS_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.write_reg(idx, data);
    endtask

    // Drain the block, then rewrite all three registers
    task automatic load_settings(input logic [TICKS_W-1:0] rate, input bit inv_on,
                                 input bit irq_on);
        req_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_put(CFG_TICKS, rate);
        cfg_put(CFG_INVERT, TICKS_W'(inv_on));
        cfg_put(CFG_IRQ_EN, TICKS_W'(irq_on));
        cfg_valid <= 1'b0;
    endtask

    function automatic req_word_t word_of(input logic [1:0] kind, input logic [1:0] idx,
                                          input logic [7:0] data, input logic [4:0] hr,
                                          input logic [5:0] mn, input logic [5:0] sc);
        req_word_t w;
        w.req_type   = kind;
        w.reg_index  = idx;
        w.write_data = data;
        w.now_hour   = hr;
        w.now_minute = mn;
        w.now_second = sc;
        return w;
    endfunction

    function automatic logic [7:0] ctrl_byte(input logic [3:0] setting, input bit alarm_on,
                                             input bit count_on);
        logic [7:0] b;
        b                 = '0;
        b[7:4]            = setting;
        b[CTRL_ALARM_BIT] = alarm_on;
        b[CTRL_COUNT_BIT] = count_on;
        return b;
    endfunction

    function automatic logic [7:0] to_bcd(input int v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    function automatic req_word_t noise_word();
        return req_word_t'(REQ_W'($urandom()));
    endfunction

    // Tick word; on a hit the current time is copied from the low bits of the alarm registers
    function automatic req_word_t next_tick(input bit hit);
        req_word_t w;
        w          = noise_word();
        w.req_type = REQ_TICK;
        if (hit)
        begin
            w.now_hour   = tracker.al_hour[4:0];
            w.now_minute = tracker.al_min[5:0];
            w.now_second = tracker.al_sec[5:0];
        end
        else if ($urandom_range(0, 9) != 0)
        begin
            w.now_hour   = 5'($urandom_range(0, 23));
            w.now_minute = 6'($urandom_range(0, 59));
            w.now_second = 6'($urandom_range(0, 59));
        end
        return w;
    endfunction

    // Control word, mostly a short period with alarm mode and counting on
    function automatic req_word_t random_control();
        req_word_t w;
        w          = noise_word();
        w.req_type = REQ_CTRL;
        if ($urandom_range(0, 4) != 0)
            w.write_data[7:4] = 4'($urandom_range(8, 12));
        w.write_data[CTRL_ALARM_BIT] = ($urandom_range(0, 4) != 0);
        w.write_data[CTRL_COUNT_BIT] = ($urandom_range(0, 4) != 0);
        return w;
    endfunction

    // Alarm register write, mostly valid BCD in range for its register
    function automatic req_word_t random_time_write();
        req_word_t w;
        bit        tidy;
        w          = noise_word();
        w.req_type = REQ_TIME;
        tidy       = ($urandom_range(0, 4) != 0);
        case ($urandom_range(0, 19))
            0:       w.reg_index = IDX_NONE;
            1, 2, 3, 4, 5, 6:
                     w.reg_index = IDX_SECOND;
            7, 8, 9, 10, 11, 12:
                     w.reg_index = IDX_MINUTE;
            default: w.reg_index = IDX_HOUR;
        endcase
        if (tidy)
            w.write_data = (w.reg_index == IDX_HOUR) ? to_bcd($urandom_range(0, 23))
                                                     : to_bcd($urandom_range(0, 59));
        return w;
    endfunction

    initial
    begin
        int                 p;
        int                 n;
        int                 pick;
        bit                 gaps_on;
        req_word_t          w;
        logic [TICKS_W-1:0] rate;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset settings: extremes of the current time,
        // a time write outside alarm mode, the longest period, BCD digits
        // above nine and the time register index with nothing behind it
        send(word_of(REQ_READ, IDX_SECOND, 8'h00, 5'd0, 6'd0, 6'd0));
        send(word_of(REQ_TICK, IDX_NONE, 8'hff, 5'd31, 6'd63, 6'd63));
        send(word_of(REQ_TIME, IDX_SECOND, 8'h59, 5'd0, 6'd0, 6'd0));
        send(word_of(REQ_CTRL, IDX_SECOND, ctrl_byte(4'd15, 1'b0, 1'b1), 5'd0, 6'd0, 6'd0));
        send(word_of(REQ_CTRL, IDX_SECOND, ctrl_byte(SET_MINUTE, 1'b1, 1'b0), 5'd0, 6'd0, 6'd0));
        send(word_of(REQ_TIME, IDX_SECOND, 8'h30, 5'd0, 6'd0, 6'd0));
        send(word_of(REQ_TIME, IDX_MINUTE, 8'hfa, 5'd0, 6'd0, 6'd0));
        send(word_of(REQ_TIME, IDX_MINUTE, 8'h45, 5'd0, 6'd0, 6'd0));
        send(word_of(REQ_TIME, IDX_HOUR, 8'h23, 5'd0, 6'd0, 6'd0));
        send(word_of(REQ_TIME, IDX_NONE, 8'h12, 5'd0, 6'd0, 6'd0));
        send(word_of(REQ_READ, IDX_SECOND, 8'h00, 5'd0, 6'd0, 6'd0));

        // The half-second counter starts from half the reset rate and is
        // only reloaded on its own expiry: run it down once with back-to-back
        // ticks, a one-tick period running alongside, and end on a matching
        // time so that both events land in the same tick
        load_settings(24'd4, 1'b0, 1'b1);
        send(word_of(REQ_CTRL, IDX_SECOND, ctrl_byte(4'd10, 1'b1, 1'b1), 5'd0, 6'd0, 6'd0));
        while (tracker.half_cnt > 1)
            send(next_tick($urandom_range(0, 1)));
        send(next_tick(1'b1));

        // Directed words at a small rate: reads leave status alone, counting
        // disabled, a zero period from the small rate and from setting zero
        load_settings(24'd4, 1'b1, 1'b1);
        send(word_of(REQ_READ, IDX_SECOND, 8'h00, 5'd0, 6'd0, 6'd0));
        send(word_of(REQ_READ, IDX_SECOND, 8'h00, 5'd0, 6'd0, 6'd0));
        send(next_tick(1'b1));
        send(next_tick(1'b1));
        send(word_of(REQ_READ, IDX_SECOND, 8'h00, 5'd0, 6'd0, 6'd0));
        send(word_of(REQ_CTRL, IDX_SECOND, ctrl_byte(4'd10, 1'b1, 1'b0), 5'd0, 6'd0, 6'd0));
        send(next_tick(1'b1));
        send(word_of(REQ_READ, IDX_SECOND, 8'h00, 5'd0, 6'd0, 6'd0));
        send(word_of(REQ_CTRL, IDX_SECOND, ctrl_byte(4'd9, 1'b1, 1'b1), 5'd0, 6'd0, 6'd0));
        send(next_tick(1'b0));
        send(word_of(REQ_CTRL, IDX_SECOND, ctrl_byte(SET_OFF, 1'b1, 1'b1), 5'd0, 6'd0, 6'd0));
        send(next_tick(1'b1));
        send(word_of(REQ_READ, IDX_SECOND, 8'h00, 5'd0, 6'd0, 6'd0));

        // Random phases. Rates of one and zero leave the half-second counter
        // stuck at zero after its next expiry and the full-scale rate makes
        // it far too long, so those three come last; the very last phase
        // runs with no idling on either side
        for (p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 3)
                rate = 24'd1;
            else if (p == PHASES - 2)
                rate = 24'd0;
            else if (p == PHASES - 1)
                rate = 24'hffffff;
            else
                rate = TICKS_W'($urandom_range(2, 40));
            load_settings(rate, p[0], p[1]);
            calm = (p == PHASES - 1);
            gaps_on = 1'b0;
            send(random_control());
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                if (n % 64 == 0)
                    gaps_on = ($urandom_range(0, 2) != 0);
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    w = next_tick($urandom_range(0, 1));
                else if (pick < 68)
                    w = random_control();
                else if (pick < 85)
                    w = random_time_write();
                else
                begin
                    w          = noise_word();
                    w.req_type = REQ_READ;
                end
                send(w);
                if (!calm && gaps_on && $urandom_range(0, 9) == 0)
                    idle_gap();
            end
        end

        // Drop valid, wait for the last owed word, then a few cycles more so
        // that any stray extra response is caught
        req_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d request words over %0d timer settings, %0d responses checked",
                 sent, PHASES + 3, tracker.checked);
        $display("%0d periodic expiries and %0d alarm hits seen, %0d mismatches",
                 tracker.expiries, tracker.alarm_hits, tracker.errors);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("rtc_periodic_alarm_timer regression: pass");
        else
            $display("rtc_periodic_alarm_timer regression: fail");
        $finish;
    end

endmodule

[sim.f]
sv/rpat_pkg.sv
sv/rpat_core.sv
sv/rtc_periodic_alarm_timer.sv
sim/tb.sv
